// ----- sv/iau_pkg.sv -----
// Package for the interval arithmetic unit: operation and status codes, field widths.
package iau_pkg;

   localparam int unsigned DATA_W = 32;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_NEG = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OVF     = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef logic signed [DATA_W-1:0]   data_type;
   typedef logic signed [DATA_W:0]     wide_type;
   typedef logic signed [2*DATA_W-1:0] prod_type;

endpackage

// ----- sv/iau_if.sv -----
// Valid/ready channel interfaces for the interval arithmetic unit request and response items.
interface iau_req_if;
   import iau_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   data_type   a_low;
   data_type   a_high;
   data_type   b_low;
   data_type   b_high;

   modport source (output valid, mode, a_low, a_high, b_low, b_high, input ready);
   modport sink   (input valid, mode, a_low, a_high, b_low, b_high, output ready);
endinterface

interface iau_rsp_if;
   import iau_pkg::*;
   logic       valid;
   logic       ready;
   data_type   r_low;
   data_type   r_high;
   logic [1:0] status;

   modport source (output valid, r_low, r_high, status, input ready);
   modport sink   (input valid, r_low, r_high, status, output ready);
endinterface

// ----- sv/interval_arithmetic_unit.sv -----
// Interval arithmetic unit: add, subtract, multiply and negate on 32-bit signed intervals.
// Four register stages lie between request accept and the response output.
// Throughput: one item per cycle while no stage stalls; the four 32x32 endpoint multipliers sit in stage two.
// Each stage holds its item while the stage after it is full and stalled.
// Reset clears the stage valid bits only; payload registers are not reset.
module interval_arithmetic_unit (
   input logic        clock,
   input logic        reset,
   iau_req_if.sink    req_bus,
   iau_rsp_if.source  rsp_bus
);
   import iau_pkg::*;

   localparam data_type INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // stage enables
   logic en1, en2, en3, en4;

   // stage 1: registered operands and operand check
   logic       v1_ff, v1_in;
   logic [1:0] mode1_ff;
   data_type   al1_ff, ah1_ff, bl1_ff, bh1_ff;
   logic       inval1_ff, inval1_in;

   // stage 2: products and linear sums
   logic       v2_ff;
   logic [1:0] mode2_ff;
   logic       inval2_ff;
   logic       spec2_ff, spec2_in;
   wide_type   lo2_ff, lo2_in, hi2_ff, hi2_in;
   prod_type   p1_ff, p2_ff, p3_ff, p4_ff;
   prod_type   p1_in, p2_in, p3_in, p4_in;

   // stage 3: range checks and pairwise min/max
   logic       v3_ff;
   logic [1:0] mode3_ff;
   logic       inval3_ff;
   logic       ovf3_ff, ovf3_in;
   data_type   lo3_ff, hi3_ff;
   data_type   mn12_ff, mn34_ff, mx12_ff, mx34_ff;
   data_type   mn12_in, mn34_in, mx12_in, mx34_in;

   // stage 4: response register
   logic       v4_ff;
   data_type   rl4_ff, rl4_in, rh4_ff, rh4_in;
   logic [1:0] st4_ff, st4_in;

   assign en4 = !v4_ff || rsp_bus.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_bus.ready = en1;
   assign v1_in         = req_bus.valid;

   assign inval1_in = (req_bus.a_low > req_bus.a_high) ||
                      ((req_bus.mode != MODE_NEG) && (req_bus.b_low > req_bus.b_high));

   always_comb begin
      lo2_in   = '0;
      hi2_in   = '0;
      spec2_in = 1'b0;
      case (mode1_ff)
         MODE_ADD: begin
            lo2_in = wide_type'(al1_ff) + wide_type'(bl1_ff);
            hi2_in = wide_type'(ah1_ff) + wide_type'(bh1_ff);
         end
         MODE_SUB: begin
            lo2_in   = wide_type'(al1_ff) - wide_type'(bh1_ff);
            hi2_in   = wide_type'(ah1_ff) - wide_type'(bl1_ff);
            spec2_in = (bl1_ff == INT_MIN) || (bh1_ff == INT_MIN);
         end
         MODE_NEG: begin
            lo2_in   = -wide_type'(ah1_ff);
            hi2_in   = -wide_type'(al1_ff);
            spec2_in = (al1_ff == INT_MIN) || (ah1_ff == INT_MIN);
         end
         default: begin
            lo2_in = '0;
            hi2_in = '0;
         end
      endcase
   end

   assign p1_in = prod_type'(al1_ff) * prod_type'(bl1_ff);
   assign p2_in = prod_type'(ah1_ff) * prod_type'(bl1_ff);
   assign p3_in = prod_type'(ah1_ff) * prod_type'(bh1_ff);
   assign p4_in = prod_type'(al1_ff) * prod_type'(bh1_ff);

   function automatic logic prod_ovf(input prod_type p);
      logic [DATA_W:0] top;
      top = p[2*DATA_W-1:DATA_W-1];
      return !((top == '0) || (top == '1));
   endfunction

   always_comb begin
      if (mode2_ff == MODE_MUL) begin
         ovf3_in = prod_ovf(p1_ff) || prod_ovf(p2_ff) || prod_ovf(p3_ff) || prod_ovf(p4_ff);
      end else begin
         ovf3_in = spec2_ff || (lo2_ff[DATA_W] != lo2_ff[DATA_W-1]) ||
                   (hi2_ff[DATA_W] != hi2_ff[DATA_W-1]);
      end
   end

   assign mn12_in = (data_type'(p1_ff[DATA_W-1:0]) < data_type'(p2_ff[DATA_W-1:0])) ?
                    data_type'(p1_ff[DATA_W-1:0]) : data_type'(p2_ff[DATA_W-1:0]);
   assign mx12_in = (data_type'(p1_ff[DATA_W-1:0]) > data_type'(p2_ff[DATA_W-1:0])) ?
                    data_type'(p1_ff[DATA_W-1:0]) : data_type'(p2_ff[DATA_W-1:0]);
   assign mn34_in = (data_type'(p3_ff[DATA_W-1:0]) < data_type'(p4_ff[DATA_W-1:0])) ?
                    data_type'(p3_ff[DATA_W-1:0]) : data_type'(p4_ff[DATA_W-1:0]);
   assign mx34_in = (data_type'(p3_ff[DATA_W-1:0]) > data_type'(p4_ff[DATA_W-1:0])) ?
                    data_type'(p3_ff[DATA_W-1:0]) : data_type'(p4_ff[DATA_W-1:0]);

   always_comb begin
      if (inval3_ff) begin
         st4_in = STATUS_INVALID;
         rl4_in = '0;
         rh4_in = '0;
      end else if (ovf3_ff) begin
         st4_in = STATUS_OVF;
         rl4_in = '0;
         rh4_in = '0;
      end else if (mode3_ff == MODE_MUL) begin
         st4_in = STATUS_OK;
         rl4_in = (mn12_ff < mn34_ff) ? mn12_ff : mn34_ff;
         rh4_in = (mx12_ff > mx34_ff) ? mx12_ff : mx34_ff;
      end else begin
         st4_in = STATUS_OK;
         rl4_in = lo3_ff;
         rh4_in = hi3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= v1_in;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         mode1_ff  <= req_bus.mode;
         al1_ff    <= req_bus.a_low;
         ah1_ff    <= req_bus.a_high;
         bl1_ff    <= req_bus.b_low;
         bh1_ff    <= req_bus.b_high;
         inval1_ff <= inval1_in;
      end
      if (en2) begin
         mode2_ff  <= mode1_ff;
         inval2_ff <= inval1_ff;
         spec2_ff  <= spec2_in;
         lo2_ff    <= lo2_in;
         hi2_ff    <= hi2_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         p3_ff     <= p3_in;
         p4_ff     <= p4_in;
      end
      if (en3) begin
         mode3_ff  <= mode2_ff;
         inval3_ff <= inval2_ff;
         ovf3_ff   <= ovf3_in;
         lo3_ff    <= lo2_ff[DATA_W-1:0];
         hi3_ff    <= hi2_ff[DATA_W-1:0];
         mn12_ff   <= mn12_in;
         mn34_ff   <= mn34_in;
         mx12_ff   <= mx12_in;
         mx34_ff   <= mx34_in;
      end
      if (en4) begin
         rl4_ff <= rl4_in;
         rh4_ff <= rh4_in;
         st4_ff <= st4_in;
      end
   end

   assign rsp_bus.valid  = v4_ff;
   assign rsp_bus.r_low  = rl4_ff;
   assign rsp_bus.r_high = rh4_ff;
   assign rsp_bus.status = st4_ff;

endmodule

// ----- sim/interval_arithmetic_unit_test.sv -----
// Testbench for the interval arithmetic unit: directed table, random items, self-checking.
`timescale 1ns / 100ps

module interval_arithmetic_unit_test;
   import iau_pkg::*;

   localparam int     NUM_DIRECTED = 25;
   localparam int     NUM_RANDOM   = 450;
   localparam int     MAX_REPORTS  = 50;
   localparam data_type D_MIN = 32'h8000_0000;
   localparam data_type D_MAX = 32'h7fff_ffff;
   localparam longint WORD_MIN = -64'sd2147483648;
   localparam longint WORD_MAX = 64'sd2147483647;

   typedef struct packed {
      logic [1:0] mode;
      data_type   a_low;
      data_type   a_high;
      data_type   b_low;
      data_type   b_high;
   } interval_req_t;

   typedef struct packed {
      data_type   r_low;
      data_type   r_high;
      logic [1:0] status;
   } interval_rsp_t;

   typedef struct packed {
      logic [1:0] mode;
      data_type   a_low;
      data_type   a_high;
      data_type   b_low;
      data_type   b_high;
      logic       known;
      data_type   r_low;
      data_type   r_high;
      logic [1:0] status;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   iau_req_if req_bus ();
   iau_rsp_if rsp_bus ();

   interval_arithmetic_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   interval_rsp_t pending_results [$];
   int            mismatch_count = 0;
   int            rsp_count      = 0;

   directed_row_t directed_rows [NUM_DIRECTED] = '{
      '{MODE_ADD, 0, 0, 0, 0,                    1'b1, 0, 0, STATUS_OK},
      '{MODE_ADD, D_MAX, D_MAX, 1, 1,            1'b1, 0, 0, STATUS_OVF},
      '{MODE_ADD, D_MIN, D_MIN, -1, -1,          1'b1, 0, 0, STATUS_OVF},
      '{MODE_ADD, D_MIN, D_MAX, 0, 0,            1'b1, D_MIN, D_MAX, STATUS_OK},
      '{MODE_ADD, 5, 4, 0, 0,                    1'b1, 0, 0, STATUS_INVALID},
      '{MODE_ADD, -30, 17, -2, 1000,             1'b0, 0, 0, STATUS_OK},
      '{MODE_SUB, 0, 0, 3, 2,                    1'b1, 0, 0, STATUS_INVALID},
      '{MODE_SUB, 0, 0, D_MIN, 0,                1'b1, 0, 0, STATUS_OVF},
      '{MODE_SUB, 0, 0, D_MIN, D_MIN,            1'b1, 0, 0, STATUS_OVF},
      '{MODE_SUB, D_MAX, D_MAX, D_MAX, D_MAX,    1'b1, 0, 0, STATUS_OK},
      '{MODE_SUB, -1, -1, D_MAX, D_MAX,          1'b1, D_MIN, D_MIN, STATUS_OK},
      '{MODE_SUB, D_MIN, 0, 1, 1,                1'b1, 0, 0, STATUS_OVF},
      '{MODE_SUB, -8, 12, -3, 40,                1'b0, 0, 0, STATUS_OK},
      '{MODE_MUL, -1, -1, D_MIN, D_MIN,          1'b1, 0, 0, STATUS_OVF},
      '{MODE_MUL, 1, 1, D_MIN, D_MAX,            1'b1, D_MIN, D_MAX, STATUS_OK},
      '{MODE_MUL, 65536, 65536, 32768, 32768,    1'b1, 0, 0, STATUS_OVF},
      '{MODE_MUL, D_MIN, D_MAX, 0, 0,            1'b1, 0, 0, STATUS_OK},
      '{MODE_MUL, -3, 2, -5, 7,                  1'b0, 0, 0, STATUS_OK},
      '{MODE_MUL, -46341, 46340, -46341, 46340,  1'b0, 0, 0, STATUS_OK},
      '{MODE_MUL, 0, 0, 1, 0,                    1'b1, 0, 0, STATUS_INVALID},
      '{MODE_NEG, 1, 5, 0, 0,                    1'b1, -5, -1, STATUS_OK},
      '{MODE_NEG, D_MIN, 0, 0, 0,                1'b1, 0, 0, STATUS_OVF},
      '{MODE_NEG, D_MAX, D_MAX, 7, -7,           1'b1, -D_MAX, -D_MAX, STATUS_OK},
      '{MODE_NEG, 1, 0, 0, 0,                    1'b1, 0, 0, STATUS_INVALID},
      '{MODE_MUL, D_MAX, 0, D_MAX, D_MAX,        1'b1, 0, 0, STATUS_INVALID}
   };

   function automatic bit outside_word(input longint v);
      return v > WORD_MAX || v < WORD_MIN;
   endfunction

   function automatic interval_rsp_t interval_result(input interval_req_t rq);
      interval_rsp_t rs;
      longint        al, ah, bl, bh, lo, hi;
      longint        prod [4];
      logic [1:0]    st;
      al = longint'($signed(rq.a_low));
      ah = longint'($signed(rq.a_high));
      bl = longint'($signed(rq.b_low));
      bh = longint'($signed(rq.b_high));
      lo = 0;
      hi = 0;
      st = STATUS_OK;
      if (al > ah || (rq.mode != MODE_NEG && bl > bh)) begin
         st = STATUS_INVALID;
      end else begin
         case (rq.mode)
            MODE_ADD: begin
               lo = al + bl;
               hi = ah + bh;
               if (outside_word(lo) || outside_word(hi)) st = STATUS_OVF;
            end
            MODE_SUB: begin
               if (bl == WORD_MIN || bh == WORD_MIN) begin
                  st = STATUS_OVF;
               end else begin
                  lo = al - bh;
                  hi = ah - bl;
                  if (outside_word(lo) || outside_word(hi)) st = STATUS_OVF;
               end
            end
            MODE_MUL: begin
               prod[0] = al * bl;
               prod[1] = ah * bl;
               prod[2] = ah * bh;
               prod[3] = al * bh;
               lo = prod[0];
               hi = prod[0];
               foreach (prod[k]) begin
                  if (outside_word(prod[k])) st = STATUS_OVF;
                  if (prod[k] < lo) lo = prod[k];
                  if (prod[k] > hi) hi = prod[k];
               end
            end
            default: begin
               if (al == WORD_MIN || ah == WORD_MIN) begin
                  st = STATUS_OVF;
               end else begin
                  lo = -ah;
                  hi = -al;
               end
            end
         endcase
      end
      if (st != STATUS_OK) begin
         lo = 0;
         hi = 0;
      end
      rs.r_low  = data_type'(lo);
      rs.r_high = data_type'(hi);
      rs.status = st;
      return rs;
   endfunction

   function automatic data_type random_endpoint();
      data_type pow;
      pow = data_type'(32'd1 << $urandom_range(0, 31));
      case ($urandom_range(0, 9))
         0, 1, 2: return data_type'($urandom_range(0, 200) - 100);
         3:       return data_type'($urandom);
         4:       return D_MIN + data_type'($urandom_range(0, 3));
         5:       return D_MAX - data_type'($urandom_range(0, 3));
         6:       return data_type'($urandom_range(0, 92682) - 46341);
         7:       return $urandom_range(0, 1) ? -pow : pow;
         default: return data_type'($urandom_range(0, 131070) - 65535);
      endcase
   endfunction

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_request(input interval_req_t rq, input logic known,
                               input interval_rsp_t fixed);
      req_bus.mode   = rq.mode;
      req_bus.a_low  = rq.a_low;
      req_bus.a_high = rq.a_high;
      req_bus.b_low  = rq.b_low;
      req_bus.b_high = rq.b_high;
      req_bus.valid  = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_results.push_back(known ? fixed : interval_result(rq));
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      interval_rsp_t want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         rsp_count++;
         if (pending_results.size() == 0) begin
            report_error($sformatf("response %0d arrived with no item pending", rsp_count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.r_low !== want.r_low)
               report_error($sformatf("response %0d r_low got %0d want %0d", rsp_count,
                                      rsp_bus.r_low, want.r_low));
            if (rsp_bus.r_high !== want.r_high)
               report_error($sformatf("response %0d r_high got %0d want %0d", rsp_count,
                                      rsp_bus.r_high, want.r_high));
            if (rsp_bus.status !== want.status)
               report_error($sformatf("response %0d status got %0d want %0d", rsp_count,
                                      rsp_bus.status, want.status));
         end
      end
   end

   initial begin
      int hold;
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         if ($urandom_range(0, 7) == 0) begin
            hold  = 60;
            stall = 0;
         end else begin
            hold  = $urandom_range(1, 12);
            stall = idle_cycles();
         end
         repeat (hold) @(negedge clock) rsp_bus.ready = 1'b1;
         repeat (stall) @(negedge clock) rsp_bus.ready = 1'b0;
      end
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      interval_req_t rq;
      interval_rsp_t fixed;
      data_type      x, y;
      int            gap;
      bit            no_gaps;
      req_bus.valid  = 1'b0;
      req_bus.mode   = MODE_ADD;
      req_bus.a_low  = '0;
      req_bus.a_high = '0;
      req_bus.b_low  = '0;
      req_bus.b_high = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         rq    = '{directed_rows[i].mode, directed_rows[i].a_low, directed_rows[i].a_high,
                   directed_rows[i].b_low, directed_rows[i].b_high};
         fixed = '{directed_rows[i].r_low, directed_rows[i].r_high, directed_rows[i].status};
         send_request(rq, directed_rows[i].known, fixed);
         gap = idle_cycles();
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end

      no_gaps = 1'b0;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if (n == NUM_RANDOM / 2) begin
            req_bus.valid = 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
         rq.mode = 2'($urandom_range(0, 3));
         x = random_endpoint();
         y = random_endpoint();
         if ($urandom_range(0, 15) != 0 && x > y) begin
            rq.a_low  = y;
            rq.a_high = x;
         end else begin
            rq.a_low  = x;
            rq.a_high = y;
         end
         x = random_endpoint();
         y = random_endpoint();
         if ($urandom_range(0, 15) != 0 && x > y) begin
            rq.b_low  = y;
            rq.b_high = x;
         end else begin
            rq.b_low  = x;
            rq.b_high = y;
         end
         send_request(rq, 1'b0, '0);
         gap = no_gaps ? 0 : idle_cycles();
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_bus.valid = 1'b0;

      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/iau_pkg.sv
sv/iau_if.sv
sv/interval_arithmetic_unit.sv
sim/interval_arithmetic_unit_test.sv
